// File: hw/rtl/pbs_pkg.sv
// pbs_pkg: field widths and request/status codes for prefix_budget_search.
// No dependencies.
package pbs_pkg;

  localparam int unsigned SumW    = 40;
  localparam int unsigned AmtW    = 30;
  localparam int unsigned CntOutW = 11;
  localparam int unsigned StatW   = 2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [StatW-1:0] STAT_QUERY  = 2'd0;
  localparam logic [StatW-1:0] STAT_APPEND = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL   = 2'd2;

  localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};

endpackage

// File: hw/rtl/prefix_budget_search.sv
// prefix_budget_search: prefix-sum table with a binary budget search.
// Depends on pbs_pkg and pbs_ram.
//
// One request at a time. An append registers its result at once: the running
// total is held in a register and, unless the table is full, the new prefix
// sum (saturating at 40 bits) is written to the RAM. A query probes the
// prefix RAM, whose single read port does one probe a cycle; probes are at
// most ceil(log2(entries + 1)), so eleven for a full table of 1024. A query
// on an empty table answers on the next cycle. A new request is taken once
// no search is running and the output register is empty or being drained.
// The RAM needs no clearing after reset.
module prefix_budget_search
  import pbs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [AmtW-1:0]    amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatW-1:0]   status_o,
  output logic [CntOutW-1:0] item_count_o,
  output logic [AmtW-1:0]    leftover_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;

  logic              state_q, state_d;
  logic [CW-1:0]     entry_count_q, entry_count_d;
  logic [SumW-1:0]   last_sum_q, last_sum_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [AmtW-1:0]   budget_q, budget_d;
  logic [AmtW-1:0]   spent_q, spent_d;
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AmtW-1:0]   leftover_q, leftover_d;

  logic              accept;
  logic              full;
  logic [SumW:0]     sum_wide;
  logic [SumW-1:0]   sum_sat;
  logic              ram_we, ram_re;
  logic [SumW-1:0]   ram_rdata;
  logic              afford;
  logic [CW-1:0]     lo_n, hi_n;
  logic [AmtW-1:0]   spent_n;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (entry_count_q == CW'(DEPTH));
  assign sum_wide   = {1'b0, last_sum_q} + {{(SumW + 1 - AmtW){1'b0}}, amount_i};
  assign sum_sat    = sum_wide[SumW] ? SUM_MAX : sum_wide[SumW-1:0];
  assign ram_we     = accept && (cmd_i == CMD_APPEND) && !full;

  assign afford  = (ram_rdata <= {{(SumW - AmtW){1'b0}}, budget_q});
  assign lo_n    = afford ? (mid_q + CW'(1)) : lo_q;
  assign hi_n    = afford ? hi_q : mid_q;
  assign spent_n = afford ? ram_rdata[AmtW-1:0] : spent_q;

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    last_sum_d    = last_sum_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    budget_d      = budget_q;
    spent_d       = spent_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    count_d       = count_q;
    leftover_d    = leftover_q;
    ram_re        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_APPEND) begin
            out_valid_d = 1'b1;
            leftover_d  = '0;
            if (full) begin
              status_d = STAT_FULL;
              count_d  = entry_count_q;
            end else begin
              status_d      = STAT_APPEND;
              entry_count_d = entry_count_q + CW'(1);
              count_d       = entry_count_q + CW'(1);
              last_sum_d    = sum_sat;
            end
          end else begin
            budget_d = amount_i;
            spent_d  = '0;
            lo_d     = '0;
            hi_d     = entry_count_q;
            mid_d    = entry_count_q >> 1;
            if (entry_count_q == '0) begin
              out_valid_d = 1'b1;
              status_d    = STAT_QUERY;
              count_d     = '0;
              leftover_d  = amount_i;
            end else begin
              ram_re  = 1'b1;
              state_d = ST_SRCH;
            end
          end
        end
      end
      ST_SRCH: begin
        lo_d    = lo_n;
        hi_d    = hi_n;
        spent_d = spent_n;
        mid_d   = lo_n + ((hi_n - lo_n) >> 1);
        if (lo_n < hi_n) begin
          ram_re = 1'b1;
        end else begin
          out_valid_d = 1'b1;
          status_d    = STAT_QUERY;
          count_d     = lo_n;
          leftover_d  = budget_q - spent_n;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  pbs_ram #(
    .WIDTH (SumW),
    .DEPTH (DEPTH)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_count_q[AW-1:0]),
    .wdata_i (sum_sat),
    .re_i    (ram_re),
    .raddr_i (mid_d[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      last_sum_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      last_sum_q    <= last_sum_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    budget_q   <= budget_d;
    spent_q    <= spent_d;
    status_q   <= status_d;
    count_q    <= count_d;
    leftover_q <= leftover_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_count_o = CntOutW'(count_q);
  assign leftover_o   = leftover_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= entry_count_q))
    else $error("search probe outside stored entries");

  a_search_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (!ram_we && $stable(entry_count_q)))
    else $error("table changed during a search");
`endif

endmodule

// File: hw/rtl/pbs_ram.sv
// pbs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbs_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
